// ===== rtl/core/scmc_pkg.sv =====
`default_nettype none

package scmc_pkg;

  localparam int unsigned MV_W        = 16;
  localparam int unsigned TICK_W      = 12;
  localparam int unsigned DAC_W       = 12;
  localparam int unsigned LED_W       = 9;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned GATE_W      = 3;
  localparam int unsigned SQ_W        = 2 * MV_W;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 32;

  // one-hot mode states
  typedef enum logic [3:0] {
    ST_STOP      = 4'b0001,
    ST_PREPARE   = 4'b0010,
    ST_RELEASE   = 4'b0100,
    ST_EMERGENCY = 4'b1000
  } mode_t;

  // mode codes as reported on the result channel
  localparam logic [MODE_W-1:0] MODE_CODE_STOP      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CODE_PREPARE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CODE_RELEASE   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CODE_EMERGENCY = 2'd3;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_SUPPLY_START = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SUPPLY_DROP  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CAP_READY    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_BOOST_ON     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_BOOST_OFF    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_EMERG_CAP    = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_EMERG_TICKS  = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_CHARGE_DAC   = 3'd7;

  // register reset values
  localparam logic [MV_W-1:0]   RST_SUPPLY_START = 16'd10000;
  localparam logic [MV_W-1:0]   RST_SUPPLY_DROP  = 16'd9000;
  localparam logic [MV_W-1:0]   RST_CAP_READY    = 16'd15000;
  localparam logic [MV_W-1:0]   RST_BOOST_ON     = 16'd28000;
  localparam logic [MV_W-1:0]   RST_BOOST_OFF    = 16'd27000;
  localparam logic [MV_W-1:0]   RST_EMERG_CAP    = 16'd10000;
  localparam logic [TICK_W-1:0] RST_EMERG_TICKS  = 12'd1000;
  localparam logic [DAC_W-1:0]  RST_CHARGE_DAC   = 12'd2048;

  // low-capacitor counter saturation
  localparam logic [TICK_W:0] COUNT_MAX    = 13'd4095;
  localparam logic [TICK_W:0] COUNT_MARGIN = 13'd100;

  localparam logic [GATE_W-1:0] GATES_OFF     = 3'd0;
  localparam logic [GATE_W-1:0] GATES_RELEASE = 3'd3;
  localparam logic [GATE_W-1:0] GATES_EMERG   = 3'd4;

  // LED bar: steps of (V^2 - 11^2) * 6 / (23^2 - 11^2), V in volts, taken in mV^2
  localparam logic [LED_W-1:0] LED_EMERG      = 9'h1e0;
  localparam logic [LED_W-1:0] LED_FULL       = 9'h1fe;
  localparam logic [LED_W-1:0] LED_DARK       = 9'h000;
  localparam logic [MV_W-1:0]  LED_MIN_CAP_MV = 16'd11000;
  localparam logic [SQ_W-1:0]  LED_SQ_BASE    = 32'd121000000;
  localparam logic [SQ_W-1:0]  LED_SQ_STEP    = 32'd68000000;
  localparam int unsigned      LED_STEPS      = 7;

  typedef struct packed {
    logic [MV_W-1:0]   supply_start_mv;
    logic [MV_W-1:0]   supply_drop_mv;
    logic [MV_W-1:0]   cap_ready_mv;
    logic [MV_W-1:0]   boost_on_mv;
    logic [MV_W-1:0]   boost_off_mv;
    logic [MV_W-1:0]   emergency_cap_mv;
    logic [TICK_W-1:0] emergency_ticks;
    logic [DAC_W-1:0]  charge_dac_code;
  } cfg_t;

  typedef struct packed {
    mode_t             mode;
    logic [TICK_W-1:0] low_cap_count;
    logic              boost_flag;
  } stat_t;

  function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
    logic [MODE_W-1:0] c;
    unique case (m)
      ST_STOP:      c = MODE_CODE_STOP;
      ST_PREPARE:   c = MODE_CODE_PREPARE;
      ST_RELEASE:   c = MODE_CODE_RELEASE;
      ST_EMERGENCY: c = MODE_CODE_EMERGENCY;
      default:      c = MODE_CODE_STOP;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/scmc_cfg_regs.sv =====
`default_nettype none

module scmc_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [scmc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [scmc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output scmc_pkg::cfg_t                          cfg_o
);
  import scmc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.supply_start_mv  <= RST_SUPPLY_START;
      cfg_r.supply_drop_mv   <= RST_SUPPLY_DROP;
      cfg_r.cap_ready_mv     <= RST_CAP_READY;
      cfg_r.boost_on_mv      <= RST_BOOST_ON;
      cfg_r.boost_off_mv     <= RST_BOOST_OFF;
      cfg_r.emergency_cap_mv <= RST_EMERG_CAP;
      cfg_r.emergency_ticks  <= RST_EMERG_TICKS;
      cfg_r.charge_dac_code  <= RST_CHARGE_DAC;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SUPPLY_START: cfg_r.supply_start_mv  <= cfg_wdata[MV_W-1:0];
        CFG_SUPPLY_DROP:  cfg_r.supply_drop_mv   <= cfg_wdata[MV_W-1:0];
        CFG_CAP_READY:    cfg_r.cap_ready_mv     <= cfg_wdata[MV_W-1:0];
        CFG_BOOST_ON:     cfg_r.boost_on_mv      <= cfg_wdata[MV_W-1:0];
        CFG_BOOST_OFF:    cfg_r.boost_off_mv     <= cfg_wdata[MV_W-1:0];
        CFG_EMERG_CAP:    cfg_r.emergency_cap_mv <= cfg_wdata[MV_W-1:0];
        CFG_EMERG_TICKS:  cfg_r.emergency_ticks  <= cfg_wdata[TICK_W-1:0];
        CFG_CHARGE_DAC:   cfg_r.charge_dac_code  <= cfg_wdata[DAC_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/core/scmc_mode_fsm.sv =====
`default_nettype none

module scmc_mode_fsm (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire scmc_pkg::cfg_t              cfg,
  input  wire logic                        upd,
  input  wire logic                        remote_stop,
  input  wire logic [scmc_pkg::MV_W-1:0]   supply_mv,
  input  wire logic [scmc_pkg::MV_W-1:0]   cap_mv,
  input  wire logic [scmc_pkg::MV_W-1:0]   out_mv,
  output scmc_pkg::mode_t                  mode_nxt,
  output logic                             boost_nxt,
  output scmc_pkg::stat_t                  stat
);
  import scmc_pkg::*;

  mode_t             mode_r;
  logic [TICK_W-1:0] count_r;
  logic [TICK_W-1:0] count_nxt;
  logic [TICK_W-1:0] count_inc;
  logic              boost_r;
  logic [TICK_W:0]   limit_sum;
  logic [TICK_W:0]   limit;

  // saturating limit for the low-capacitor counter
  assign limit_sum = {1'b0, cfg.emergency_ticks} + COUNT_MARGIN;
  assign limit     = (limit_sum > COUNT_MAX) ? COUNT_MAX : limit_sum;
  assign count_inc = ({1'b0, count_r} < limit) ? count_r + 1'b1 : count_r;

  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    if (remote_stop) begin
      mode_nxt = ST_STOP;
    end else begin
      unique case (mode_r)
        ST_STOP: begin
          if (supply_mv > cfg.supply_start_mv) mode_nxt = ST_PREPARE;
        end
        ST_PREPARE: begin
          if (supply_mv < cfg.supply_drop_mv) mode_nxt = ST_STOP;
          else if (cap_mv > cfg.cap_ready_mv) mode_nxt = ST_RELEASE;
        end
        ST_RELEASE: begin
          if (supply_mv < cfg.supply_drop_mv) begin
            mode_nxt = ST_STOP;
          end else if (cfg.emergency_ticks == '0) begin
            count_nxt = '0;
          end else if (cap_mv < cfg.emergency_cap_mv) begin
            count_nxt = count_inc;
            if (count_inc > cfg.emergency_ticks) mode_nxt = ST_EMERGENCY;
          end else begin
            count_nxt = '0;
          end
        end
        ST_EMERGENCY: ;
        default: mode_nxt = ST_STOP;
      endcase
    end
  end

  // clear wins over set
  always_comb begin
    boost_nxt = boost_r;
    if (out_mv > cfg.boost_on_mv) boost_nxt = 1'b1;
    if (out_mv < cfg.boost_off_mv) boost_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ST_STOP;
      count_r <= '0;
      boost_r <= 1'b0;
    end else if (upd) begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
      boost_r <= boost_nxt;
    end
  end

  assign stat.mode          = mode_r;
  assign stat.low_cap_count = count_r;
  assign stat.boost_flag    = boost_r;

endmodule

`default_nettype wire

// ===== rtl/core/scmc_led_map.sv =====
`default_nettype none

module scmc_led_map (
  input  wire scmc_pkg::mode_t             mode,
  input  wire logic                        cap_low,
  input  wire logic [scmc_pkg::SQ_W-1:0]   cap_sq,
  output logic [scmc_pkg::LED_W-1:0]       led_mask
);
  import scmc_pkg::*;

  logic [LED_STEPS-1:0] hit;
  logic [2:0]           k;
  logic [2:0]           unlight;
  logic [LED_W-1:0]     bar;

  // thermometer of crossed steps; its popcount is the step index, capped at 7
  always_comb begin
    for (int j = 0; j < LED_STEPS; j++) begin
      hit[j] = cap_sq >= (LED_SQ_BASE + LED_SQ_STEP * SQ_W'(j + 1));
    end
  end

  assign k       = 3'($countones(hit));
  assign unlight = 3'(LED_STEPS) - k;
  assign bar     = LED_FULL >> unlight;

  always_comb begin
    priority if (mode == ST_EMERGENCY) led_mask = LED_EMERG;
    else if (cap_low) led_mask = LED_DARK;
    else led_mask = bar;
  end

endmodule

`default_nettype wire

// ===== rtl/core/supercap_charge_mode_controller.sv =====
`default_nettype none

// Channel   Dir  Handshake             Payload
// in_*      in   in_tvalid/in_tready   remote_stop, supply_mv, cap_mv, out_mv
// out_*     out  out_tvalid/out_tready mode, switch_gates, boost_gate, dac_code, led_mask
// cfg_*     in   cfg_we                register index cfg_addr, data cfg_wdata
//
// Three register stages: input, state update plus capacitor squaring, result.
// One transaction per cycle unless out_tready stalls; out_tvalid rises once the input
// has passed the stage 2 and result registers. Each stage advances when it is empty or
// the next one is advancing, so input is taken while a result waits if stage 1 or 2 is
// empty. Mode, counter and boost state update once per transaction in the second stage.
// Synchronous reset clears valids and state, not payload; ready in the cycle after reset.

module supercap_charge_mode_controller (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [0] remote_stop, [16:1] supply_mv, [32:17] cap_mv, [48:33] out_mv, rest zero
  input  wire logic [scmc_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [1:0] mode, [4:2] switch_gates, [5] boost_gate, [17:6] dac_code,
  // [26:18] led_mask, rest zero
  output logic [scmc_pkg::OUT_TDATA_W-1:0]         out_tdata,
  input  wire logic                                cfg_we,
  input  wire logic [scmc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [scmc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import scmc_pkg::*;

  cfg_t  cfg;
  stat_t core_stat;

  // stage 1: input register
  logic            s1_v_r;
  logic            s1_rstop_r;
  logic [MV_W-1:0] s1_supply_r;
  logic [MV_W-1:0] s1_cap_r;
  logic [MV_W-1:0] s1_out_r;

  // stage 2: updated mode and squared capacitor voltage
  logic            s2_v_r;
  mode_t           s2_mode_r;
  logic            s2_boost_r;
  logic            s2_cap_low_r;
  logic [SQ_W-1:0] s2_sq_r;

  // stage 3: result register
  logic              s3_v_r;
  logic [MODE_W-1:0] s3_mode_r;
  logic [GATE_W-1:0] s3_gates_r;
  logic              s3_boost_r;
  logic [DAC_W-1:0]  s3_dac_r;
  logic [LED_W-1:0]  s3_led_r;

  logic s1_rdy, s2_rdy, s3_rdy;
  logic in_acc, upd;

  mode_t             mode_nxt;
  logic              boost_nxt;
  logic [SQ_W-1:0]   sq_nxt;
  logic [GATE_W-1:0] gates_nxt;
  logic [DAC_W-1:0]  dac_nxt;
  logic [LED_W-1:0]  led_nxt;

  assign s3_rdy    = !s3_v_r || out_tready;
  assign s2_rdy    = !s2_v_r || s3_rdy;
  assign s1_rdy    = !s1_v_r || s2_rdy;
  assign in_tready = s1_rdy;
  assign in_acc    = in_tvalid && s1_rdy;
  assign upd       = s1_v_r && s2_rdy;

  scmc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  scmc_mode_fsm u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .upd         (upd),
    .remote_stop (s1_rstop_r),
    .supply_mv   (s1_supply_r),
    .cap_mv      (s1_cap_r),
    .out_mv      (s1_out_r),
    .mode_nxt    (mode_nxt),
    .boost_nxt   (boost_nxt),
    .stat        (core_stat)
  );

  assign sq_nxt = SQ_W'(s1_cap_r) * SQ_W'(s1_cap_r);

  scmc_led_map u_led (
    .mode     (s2_mode_r),
    .cap_low  (s2_cap_low_r),
    .cap_sq   (s2_sq_r),
    .led_mask (led_nxt)
  );

  always_comb begin
    gates_nxt = GATES_OFF;
    unique case (s2_mode_r)
      ST_RELEASE:   gates_nxt = GATES_RELEASE;
      ST_EMERGENCY: gates_nxt = GATES_EMERG;
      default:      gates_nxt = GATES_OFF;
    endcase
  end

  assign dac_nxt = (s2_mode_r == ST_PREPARE) ? cfg.charge_dac_code : '0;

  // valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= in_tvalid;
      if (s2_rdy) s2_v_r <= s1_v_r;
      if (s3_rdy) s3_v_r <= s2_v_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_rstop_r  <= in_tdata[0];
      s1_supply_r <= in_tdata[16:1];
      s1_cap_r    <= in_tdata[32:17];
      s1_out_r    <= in_tdata[48:33];
    end
    if (upd) begin
      s2_mode_r    <= mode_nxt;
      s2_boost_r   <= boost_nxt;
      s2_cap_low_r <= s1_cap_r < LED_MIN_CAP_MV;
      s2_sq_r      <= sq_nxt;
    end
    if (s2_v_r && s3_rdy) begin
      s3_mode_r  <= mode_code(s2_mode_r);
      s3_gates_r <= gates_nxt;
      s3_boost_r <= s2_boost_r;
      s3_dac_r   <= dac_nxt;
      s3_led_r   <= led_nxt;
    end
  end

  assign out_tvalid = s3_v_r;
  assign out_tdata  = {5'd0, s3_led_r, s3_dac_r, s3_boost_r, s3_gates_r, s3_mode_r};

  a_remote_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (upd && s1_rstop_r) |=> (core_stat.mode == ST_STOP))
    else $error("remote stop did not force stop mode");

  a_emerg_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ((core_stat.mode == ST_EMERGENCY) && !(upd && s1_rstop_r))
      |=> (core_stat.mode == ST_EMERGENCY))
    else $error("emergency left without remote stop");

  a_dac_prepare: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && (s3_dac_r != '0)) |-> (s3_mode_r == MODE_CODE_PREPARE))
    else $error("dac code driven outside prepare");

  a_emerg_led: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && (s3_mode_r == MODE_CODE_EMERGENCY))
      |-> ((s3_led_r == LED_EMERG) && (s3_gates_r == GATES_EMERG)))
    else $error("emergency result fields inconsistent");

endmodule

`default_nettype wire
